[sv/thresholded_box_filter_unit_defines.svh]
// assertion macros for the thresholded box filter checker
// no dependencies
`ifndef THRESHOLDED_BOX_FILTER_UNIT_DEFINES_SVH
`define THRESHOLDED_BOX_FILTER_UNIT_DEFINES_SVH

// implication to the next cycle, off while reset is high
`define TBF_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

// implication to the next cycle, also checked across reset
`define TBF_ASSERT_RESET(label, clk, rst, post, msg) \
   label: assert property (@(posedge clk) (rst) |=> (post)) else $error(msg);

`endif

[sv/tbf_pkg.sv]
// shared constants, types and codes of the thresholded box filter
// no dependencies
package tbf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MAX_WINDOW = 32;

   localparam int PIX_W   = 8;
   localparam int DIM_W   = 11;
   localparam int WINR_W  = 6;
   localparam int THR_W   = 12;
   localparam int CSR_W   = 12;
   localparam int IDX_W   = 2;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int SLOT_W  = $clog2(MAX_WINDOW);
   localparam int WIN_W   = $clog2(MAX_WINDOW) + 1;
   localparam int ROW_W   = $clog2(MAX_HEIGHT + MAX_WINDOW);
   localparam int LINE_AW = SLOT_W + COL_W;
   localparam int LINE_DEPTH = MAX_WINDOW * MAX_WIDTH;
   localparam int CSUM_W  = $clog2(MAX_WINDOW * 255 + 1);
   localparam int WSUM_W  = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
   localparam int N_W     = $clog2(MAX_WINDOW * MAX_WINDOW);
   localparam int THRN_W  = THR_W + N_W;
   localparam int LAT_W   = $clog2((MAX_WINDOW / 2) * (MAX_WIDTH + 1) + 1);
   localparam int POS_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH * MAX_WINDOW);
   localparam int Q_W     = 9;
   localparam int CNT_W   = $clog2(Q_W);
   localparam int DIV_W   = WSUM_W + 1;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int SETTLE_W = 2;
   localparam int SETTLE_CYCLES = 3;

   localparam logic [IDX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [IDX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [IDX_W-1:0] CSR_WINDOW_SIZE    = 2'd2;
   localparam logic [IDX_W-1:0] CSR_MEAN_THRESHOLD = 2'd3;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef struct packed {
      logic [N_W-1:0]    n;
      logic [THRN_W-1:0] thr_n;
      logic              lat_zero;
   } cfg_type;

   typedef struct packed {
      logic              is_pixel;
      logic [PIX_W-1:0]  px;
      logic [COL_W-1:0]  col;
      logic [SLOT_W-1:0] slot;
      logic [SLOT_W-1:0] old_slot;
      logic [COL_W-1:0]  colw;
      logic              row_first;
      logic              row_sub;
      logic              col_first;
      logic              col_sub;
      logic              win_ok;
      logic              emit;
      logic [SLOT_W-1:0] oslot;
      logic [COL_W-1:0]  ocol;
      logic              frame_end;
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_DIV,
      ST_OUT
   } back_state_type;

endpackage

[sv/tbf_front.sv]
// front part: configuration registers, frame position tracking, item classification
// depends on tbf_pkg
module tbf_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [tbf_pkg::IDX_W-1:0]   csr_index,
   input  logic [tbf_pkg::CSR_W-1:0]   csr_wdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [tbf_pkg::PIX_W-1:0]   req_tdata,
   input  logic                        req_tuser,
   output logic                        q_push,
   output tbf_pkg::op_type             q_entry,
   input  logic                        q_full,
   output tbf_pkg::cfg_type            cfg
);

   logic [tbf_pkg::DIM_W-1:0]  width_ff, height_ff;
   logic [tbf_pkg::WINR_W-1:0] winr_ff;
   logic [tbf_pkg::THR_W-1:0]  thr_ff;
   logic [tbf_pkg::SETTLE_W-1:0] settle_ff, settle_in;

   logic [tbf_pkg::DIM_W-1:0]  wcl, hcl;
   logic [tbf_pkg::WIN_W-1:0]  wincl;
   logic [tbf_pkg::DIM_W-1:0]  w_ff, h_ff;
   logic [tbf_pkg::WIN_W-1:0]  win_ff, d_ff;
   logic [tbf_pkg::N_W-1:0]    n_ff;
   logic [tbf_pkg::LAT_W-1:0]  lat_ff;
   logic [tbf_pkg::POS_W-1:0]  area_ff, last_ff;
   logic [tbf_pkg::THRN_W-1:0] thrn_ff;

   logic [tbf_pkg::COL_W-1:0]  col_ff, col_in, ocol_ff, ocol_in;
   logic [tbf_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [tbf_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [tbf_pkg::SLOT_W-1:0] oslot_ff, oslot_in;

   logic accept, real_px, drop, geo_write, emit, frame_end;

   // clamped geometry
   always_comb begin
      if (width_ff == '0) begin
         wcl = tbf_pkg::DIM_W'(1);
      end else if (width_ff > tbf_pkg::DIM_W'(tbf_pkg::MAX_WIDTH)) begin
         wcl = tbf_pkg::DIM_W'(tbf_pkg::MAX_WIDTH);
      end else begin
         wcl = width_ff;
      end
      if (height_ff == '0) begin
         hcl = tbf_pkg::DIM_W'(1);
      end else if (height_ff > tbf_pkg::DIM_W'(tbf_pkg::MAX_HEIGHT)) begin
         hcl = tbf_pkg::DIM_W'(tbf_pkg::MAX_HEIGHT);
      end else begin
         hcl = height_ff;
      end
      if (winr_ff < tbf_pkg::WINR_W'(2)) begin
         wincl = tbf_pkg::WIN_W'(2);
      end else if (winr_ff > tbf_pkg::WINR_W'(tbf_pkg::MAX_WINDOW)) begin
         wincl = tbf_pkg::WIN_W'(tbf_pkg::MAX_WINDOW);
      end else begin
         wincl = tbf_pkg::WIN_W'(winr_ff);
      end
   end

   // derived geometry, three register stages
   always_ff @(posedge clock) begin
      w_ff    <= wcl;
      h_ff    <= hcl;
      win_ff  <= wincl;
      d_ff    <= wincl - tbf_pkg::WIN_W'(1) - (wincl >> 1);
      n_ff    <= tbf_pkg::N_W'(wincl) * tbf_pkg::N_W'(wincl) - tbf_pkg::N_W'(1);
      lat_ff  <= tbf_pkg::LAT_W'(d_ff) * tbf_pkg::LAT_W'(w_ff) + tbf_pkg::LAT_W'(d_ff);
      area_ff <= tbf_pkg::POS_W'(w_ff) * tbf_pkg::POS_W'(h_ff);
      thrn_ff <= tbf_pkg::THRN_W'(thr_ff) * tbf_pkg::THRN_W'(n_ff);
      last_ff <= area_ff - tbf_pkg::POS_W'(1) + tbf_pkg::POS_W'(lat_ff);
   end

   assign cfg.n        = n_ff;
   assign cfg.thr_n    = thrn_ff;
   assign cfg.lat_zero = (lat_ff == '0);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= tbf_pkg::DIM_W'(1024);
         height_ff <= tbf_pkg::DIM_W'(1024);
         winr_ff   <= tbf_pkg::WINR_W'(30);
         thr_ff    <= tbf_pkg::THR_W'(320);
      end else if (csr_we) begin
         case (csr_index)
            tbf_pkg::CSR_IMAGE_WIDTH:    width_ff  <= csr_wdata[tbf_pkg::DIM_W-1:0];
            tbf_pkg::CSR_IMAGE_HEIGHT:   height_ff <= csr_wdata[tbf_pkg::DIM_W-1:0];
            tbf_pkg::CSR_WINDOW_SIZE:    winr_ff   <= csr_wdata[tbf_pkg::WINR_W-1:0];
            tbf_pkg::CSR_MEAN_THRESHOLD: thr_ff    <= csr_wdata[tbf_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   assign geo_write = csr_we && (csr_index != tbf_pkg::CSR_MEAN_THRESHOLD);

   always_comb begin
      if (csr_we) begin
         settle_in = tbf_pkg::SETTLE_W'(tbf_pkg::SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - tbf_pkg::SETTLE_W'(1);
      end else begin
         settle_in = settle_ff;
      end
   end

   // classification
   assign req_tready = !q_full && (settle_ff == '0);
   assign accept     = req_tvalid && req_tready;
   assign real_px    = row_ff < tbf_pkg::ROW_W'(h_ff);
   assign drop       = real_px && (req_tuser == tbf_pkg::CMD_FLUSH);
   assign emit       = pos_ff >= tbf_pkg::POS_W'(lat_ff);
   assign frame_end  = pos_ff == last_ff;
   assign q_push     = accept && !drop;

   always_comb begin
      q_entry.is_pixel  = real_px;
      q_entry.px        = req_tdata;
      q_entry.col       = col_ff;
      q_entry.slot      = row_ff[tbf_pkg::SLOT_W-1:0];
      q_entry.old_slot  = row_ff[tbf_pkg::SLOT_W-1:0] - win_ff[tbf_pkg::SLOT_W-1:0];
      q_entry.colw      = col_ff - tbf_pkg::COL_W'(win_ff);
      q_entry.row_first = (row_ff == '0);
      q_entry.row_sub   = row_ff >= tbf_pkg::ROW_W'(win_ff);
      q_entry.col_first = (col_ff == '0);
      q_entry.col_sub   = col_ff >= tbf_pkg::COL_W'(win_ff);
      q_entry.win_ok    = (row_ff >= tbf_pkg::ROW_W'(win_ff) - tbf_pkg::ROW_W'(1))
                       && (col_ff >= tbf_pkg::COL_W'(win_ff) - tbf_pkg::COL_W'(1));
      q_entry.emit      = emit;
      q_entry.oslot     = oslot_ff;
      q_entry.ocol      = ocol_ff;
      q_entry.frame_end = frame_end;
   end

   // position counters
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      pos_in   = pos_ff;
      ocol_in  = ocol_ff;
      oslot_in = oslot_ff;
      if (geo_write || (q_push && frame_end)) begin
         col_in   = '0;
         row_in   = '0;
         pos_in   = '0;
         ocol_in  = '0;
         oslot_in = '0;
      end else if (q_push) begin
         pos_in = pos_ff + tbf_pkg::POS_W'(1);
         if ({1'b0, col_ff} + tbf_pkg::DIM_W'(1) >= w_ff) begin
            col_in = '0;
            row_in = row_ff + tbf_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + tbf_pkg::COL_W'(1);
         end
         if (emit) begin
            if ({1'b0, ocol_ff} + tbf_pkg::DIM_W'(1) >= w_ff) begin
               ocol_in  = '0;
               oslot_in = oslot_ff + tbf_pkg::SLOT_W'(1);
            end else begin
               ocol_in = ocol_ff + tbf_pkg::COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= tbf_pkg::SETTLE_W'(tbf_pkg::SETTLE_CYCLES);
         col_ff    <= '0;
         row_ff    <= '0;
         pos_ff    <= '0;
         ocol_ff   <= '0;
         oslot_ff  <= '0;
      end else begin
         settle_ff <= settle_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pos_ff    <= pos_in;
         ocol_ff   <= ocol_in;
         oslot_ff  <= oslot_in;
      end
   end

endmodule

[sv/tbf_queue.sv]
// four-entry queue of classified items between front and back
// depends on tbf_pkg
module tbf_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  tbf_pkg::op_type entry_in,
   input  logic            pop,
   output tbf_pkg::op_type head,
   output logic            full,
   output logic            empty
);

   tbf_pkg::op_type entry_ff [tbf_pkg::QDEPTH];
   logic [tbf_pkg::QPTR_W-1:0] wr_ff, rd_ff;
   logic [tbf_pkg::QPTR_W:0]   count_ff, count_in;

   assign full  = count_ff == (tbf_pkg::QPTR_W+1)'(tbf_pkg::QDEPTH);
   assign empty = count_ff == '0;
   assign head  = entry_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (tbf_pkg::QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (tbf_pkg::QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + tbf_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + tbf_pkg::QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

[sv/tbf_ram.sv]
// generic ram, one write port, two registered read ports
// no dependencies
module tbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff, rd_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_a_ff <= mem_ff[raddr_a];
      rd_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rd_a_ff;
   assign rdata_b = rd_b_ff;

endmodule

[sv/tbf_back.sv]
// back part: line and column sum memories, window sum, threshold, divider, output register
// depends on tbf_pkg and tbf_ram
module tbf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tbf_pkg::cfg_type           cfg,
   input  logic                       q_empty,
   input  tbf_pkg::op_type            q_head,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [tbf_pkg::PIX_W-1:0]  rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);

   tbf_pkg::back_state_type state_ff, state_in;
   tbf_pkg::op_type op_ff;

   logic [tbf_pkg::PIX_W-1:0]  line_old, line_orig, orig, orig_ff, pix_out;
   logic [tbf_pkg::CSUM_W-1:0] col_old, col_w, cs_new, sub_line, sub_col;
   logic [tbf_pkg::WSUM_W-1:0] ws_ff, ws_new;
   logic [tbf_pkg::DIV_W-1:0]  rem_ff, den_ff;
   logic [tbf_pkg::DIV_W:0]    trial;
   logic [tbf_pkg::Q_W-1:0]    q_ff;
   logic [tbf_pkg::CNT_W-1:0]  cnt_ff;
   logic rep_ff, replace, mem_we, out_load, div_last;
   logic rsp_valid_ff, rsp_user_ff, rsp_last_ff;
   logic [tbf_pkg::PIX_W-1:0] rsp_data_ff;

   tbf_ram #(
      .WIDTH (tbf_pkg::PIX_W),
      .DEPTH (tbf_pkg::LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .we      (mem_we),
      .waddr   ({op_ff.slot, op_ff.col}),
      .wdata   (op_ff.px),
      .raddr_a ({q_head.old_slot, q_head.col}),
      .raddr_b ({q_head.oslot, q_head.ocol}),
      .rdata_a (line_old),
      .rdata_b (line_orig)
   );

   tbf_ram #(
      .WIDTH (tbf_pkg::CSUM_W),
      .DEPTH (tbf_pkg::MAX_WIDTH)
   ) u_colsum (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (op_ff.col),
      .wdata   (cs_new),
      .raddr_a (q_head.col),
      .raddr_b (q_head.colw),
      .rdata_a (col_old),
      .rdata_b (col_w)
   );

   // running column and window sums, threshold compare, divider trial and output pixel select
   always_comb begin
      sub_line = op_ff.row_sub ? tbf_pkg::CSUM_W'(line_old) : '0;
      sub_col  = op_ff.col_sub ? col_w : '0;
      if (op_ff.row_first) begin
         cs_new = tbf_pkg::CSUM_W'(op_ff.px);
      end else begin
         cs_new = col_old + tbf_pkg::CSUM_W'(op_ff.px) - sub_line;
      end
      if (op_ff.col_first) begin
         ws_new = tbf_pkg::WSUM_W'(cs_new);
      end else begin
         ws_new = ws_ff + tbf_pkg::WSUM_W'(cs_new) - tbf_pkg::WSUM_W'(sub_col);
      end
      orig    = (cfg.lat_zero && op_ff.is_pixel) ? op_ff.px : line_orig;
      replace = op_ff.is_pixel && op_ff.win_ok
             && ({ws_new, 4'b0000} > tbf_pkg::THRN_W'(cfg.thr_n));
      trial    = {1'b0, rem_ff} - {1'b0, den_ff};
      div_last = cnt_ff == tbf_pkg::CNT_W'(tbf_pkg::Q_W - 1);
      if (!rep_ff) begin
         pix_out = orig_ff;
      end else if (q_ff[tbf_pkg::Q_W-1]) begin
         pix_out = '1;
      end else begin
         pix_out = q_ff[tbf_pkg::PIX_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tbf_pkg::ST_IDLE: begin
            if (!q_empty) begin
               state_in = tbf_pkg::ST_CALC;
            end
         end
         tbf_pkg::ST_CALC: begin
            if (!op_ff.emit) begin
               state_in = tbf_pkg::ST_IDLE;
            end else if (replace) begin
               state_in = tbf_pkg::ST_DIV;
            end else begin
               state_in = tbf_pkg::ST_OUT;
            end
         end
         tbf_pkg::ST_DIV: begin
            if (div_last) begin
               state_in = tbf_pkg::ST_OUT;
            end
         end
         tbf_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = tbf_pkg::ST_IDLE;
            end
         end
         default: state_in = tbf_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop    = 1'b0;
      mem_we   = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         tbf_pkg::ST_IDLE: q_pop    = !q_empty;
         tbf_pkg::ST_CALC: mem_we   = op_ff.is_pixel;
         tbf_pkg::ST_OUT:  out_load = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff <= q_head;
      end
      if (state_ff == tbf_pkg::ST_CALC) begin
         if (op_ff.is_pixel) begin
            ws_ff <= ws_new;
         end
         orig_ff <= orig;
         rep_ff  <= replace;
         rem_ff  <= tbf_pkg::DIV_W'(ws_new);
         den_ff  <= tbf_pkg::DIV_W'(cfg.n) << (tbf_pkg::Q_W - 1);
         q_ff    <= '0;
         cnt_ff  <= '0;
      end else if (state_ff == tbf_pkg::ST_DIV) begin
         if (!trial[tbf_pkg::DIV_W]) begin
            rem_ff <= trial[tbf_pkg::DIV_W-1:0];
         end
         q_ff   <= {q_ff[tbf_pkg::Q_W-2:0], !trial[tbf_pkg::DIV_W]};
         den_ff <= den_ff >> 1;
         cnt_ff <= cnt_ff + tbf_pkg::CNT_W'(1);
      end
      if (out_load) begin
         rsp_data_ff <= pix_out;
         rsp_user_ff <= rep_ff;
         rsp_last_ff <= op_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[sv/thresholded_box_filter_unit.sv]
// top level of the thresholded box filter: front, queue and back
// depends on tbf_pkg, tbf_front, tbf_queue, tbf_back
//
// channel  | direction | tdata          | tuser          | tlast
// req_     | in        | pixel_in       | cmd            | -
// rsp_     | out       | pixel_out      | was_replaced   | frame_end
// csr_     | in        | write index 0 width, 1 height, 2 window, 3 threshold
//
// front takes one beat per cycle unless settling or the four-entry queue is full
// back moves an item without result through idle and calc, a plain result
// through idle, calc and out, a replaced pixel also through div (9-step divider)
// req_tready stays low after reset and each csr write until settle_ff runs down
// reset is synchronous; the memories are not cleared
module thresholded_box_filter_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [tbf_pkg::PIX_W-1:0]   req_tdata,   // pixel_in
   input  logic                        req_tuser,   // cmd
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [tbf_pkg::PIX_W-1:0]   rsp_tdata,   // pixel_out
   output logic                        rsp_tuser,   // was_replaced
   output logic                        rsp_tlast,
   input  logic                        csr_we,
   input  logic [tbf_pkg::IDX_W-1:0]   csr_index,
   input  logic [tbf_pkg::CSR_W-1:0]   csr_wdata
);

   tbf_pkg::cfg_type cfg;
   tbf_pkg::op_type  q_entry, q_head;
   logic q_push, q_pop, q_full, q_empty;

   tbf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_push     (q_push),
      .q_entry    (q_entry),
      .q_full     (q_full),
      .cfg        (cfg)
   );

   tbf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .entry_in (q_entry),
      .pop      (q_pop),
      .head     (q_head),
      .full     (q_full),
      .empty    (q_empty)
   );

   tbf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[sv/tbf_checker.sv]
// port checker for the thresholded box filter, bound to the top level
// depends on tbf_pkg and thresholded_box_filter_unit_defines.svh
`include "thresholded_box_filter_unit_defines.svh"

module tbf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [tbf_pkg::PIX_W-1:0]   req_tdata,
   input logic                        req_tuser,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [tbf_pkg::PIX_W-1:0]   rsp_tdata,
   input logic                        rsp_tuser,
   input logic                        rsp_tlast,
   input logic                        csr_we,
   input logic [tbf_pkg::IDX_W-1:0]   csr_index,
   input logic [tbf_pkg::CSR_W-1:0]   csr_wdata
);

   `TBF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "rsp beat changed while stalled")
   `TBF_ASSERT_NEXT(a_csr_settle, clock, reset, csr_we, !req_tready, "req_tready high right after csr write")
   `TBF_ASSERT_NEXT(a_settle_two, clock, reset, csr_we ##1 !csr_we, !req_tready, "req_tready high two cycles after csr write")
   `TBF_ASSERT_RESET(a_reset_quiet, clock, reset, !rsp_tvalid && !req_tready, "ports not quiet after reset")

endmodule

bind thresholded_box_filter_unit tbf_checker u_chk (.*);
